// ===== sv/ttme_pkg.sv =====
`default_nettype none
package ttme_pkg;

  localparam int TIME_W    = 48;
  localparam int IVAL_W    = 24;
  localparam int TEMPO_W   = 20;
  localparam int COUNT_W   = 4;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int QUO_W     = 34;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  localparam logic [QUO_W-1:0]   TEMPO_NUM    = 34'd15360000000;
  localparam logic [TEMPO_W-1:0] TEMPO_SAT    = '1;
  localparam logic [IVAL_W-1:0]  GAP_THR_RST  = 24'd2000000;
  localparam logic [TEMPO_W-1:0] TEMPO_MIN_RST = 20'd15360;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX_RST = 20'd61440;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOWNBEAT,
    KIND_PHASE_RESET,
    KIND_SINGLE,
    KIND_OUT_OF_RANGE
  } tap_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAP_THRESHOLD,
    REG_TEMPO_MIN,
    REG_TEMPO_MAX
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAP,
    ST_CAND,
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_END,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic downbeat;
    logic store;
    logic rd_cand;
    logic load_cand;
    logic scan;
    logic take_med;
    logic next_i;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic new_seq;
    logic scan_last;
    logic cand_last;
    logic hit;
    logic div_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/ttme_if.sv =====
`default_nettype none
interface ttme_tap_if import ttme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] tap_time_us;

  modport source (output valid, output tap_time_us, input ready);
  modport sink (input valid, input tap_time_us, output ready);
endinterface

interface ttme_res_if import ttme_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  tap_kind;
  logic [TEMPO_W-1:0] tempo_q8;
  logic [COUNT_W-1:0] interval_count;

  modport source (output valid, output tap_kind, output tempo_q8, output interval_count,
                  input ready);
  modport sink (input valid, input tap_kind, input tempo_q8, input interval_count,
                output ready);
endinterface
`default_nettype wire

// ===== sv/ttme_ram.sv =====
`default_nettype none
module ttme_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/ttme_ctrl.sv =====
`default_nettype none
module ttme_ctrl import ttme_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    tap_valid,
  output logic         tap_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tap_valid) state_next = ST_GAP;
      end
      ST_GAP: begin
        state_next = status.new_seq ? ST_FINISH : ST_CAND;
      end
      ST_CAND:     state_next = ST_LOAD;
      ST_LOAD:     state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = (status.hit || status.cand_last) ? ST_DIV : ST_CAND;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    tap_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        tap_ready  = 1'b1;
        cmd.accept = tap_valid;
      end
      ST_GAP: begin
        cmd.downbeat = status.new_seq;
        cmd.store    = !status.new_seq;
      end
      ST_CAND:     cmd.rd_cand = 1'b1;
      ST_LOAD:     cmd.load_cand = 1'b1;
      ST_SCAN:     cmd.scan = 1'b1;
      ST_SCAN_END: cmd = '0;
      ST_CHECK: begin
        cmd.take_med = status.hit || status.cand_last;
        cmd.next_i   = !(status.hit || status.cand_last);
      end
      ST_DIV:      cmd.div_step = 1'b1;
      ST_FINISH:   cmd.load_out = status.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/ttme_dp.sv =====
`default_nettype none
module ttme_dp import ttme_pkg::*; #(
  parameter int HISTORY_DEPTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [TIME_W-1:0]    tap_time_us,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic [KIND_W-1:0]         tap_kind,
  output logic [TEMPO_W-1:0]        tempo_q8,
  output logic [COUNT_W-1:0]        interval_count
);

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  logic [IVAL_W-1:0]    gap_thr;
  logic [TEMPO_W-1:0]   tempo_min;
  logic [TEMPO_W-1:0]   tempo_max;
  logic                 have_previous;
  logic [TIME_W-1:0]    last_time;
  logic [TIME_W-1:0]    now_time;
  logic                 downbeat;
  logic [IDX_W-1:0]     wr_pos;
  logic [CNT_W-1:0]     fill;
  logic [IDX_W-1:0]     cand_idx;
  logic [IDX_W-1:0]     scan_idx;
  logic [IVAL_W-1:0]    cand;
  logic [CNT_W-1:0]     below;
  logic [CNT_W-1:0]     upto;
  logic                 cmp_valid;
  logic [IVAL_W-1:0]    med;
  logic [QUO_W-1:0]     num_sh;
  logic [QUO_W-1:0]     quo;
  logic [IVAL_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [TIME_W-1:0]    gap_full;
  logic [IDX_W-1:0]     ram_raddr;
  logic [IVAL_W-1:0]    ram_rdata;
  logic [CNT_W-1:0]     mid_rank;
  logic [IVAL_W:0]      trial;
  logic                 trial_ge;
  logic [TEMPO_W-1:0]   tempo_val;
  tap_kind_t            kind_val;

  assign gap_full  = now_time - last_time;
  assign ram_raddr = cmd.rd_cand ? cand_idx : scan_idx;
  assign mid_rank  = fill >> 1;
  assign trial     = {rem, num_sh[QUO_W-1]};
  assign trial_ge  = trial >= {1'b0, med};

  assign status.new_seq   = !have_previous || (gap_full > TIME_W'(gap_thr));
  assign status.scan_last = CNT_W'(scan_idx) == fill - CNT_W'(1);
  assign status.cand_last = CNT_W'(cand_idx) == fill - CNT_W'(1);
  assign status.hit       = (below <= mid_rank) && (mid_rank < upto);
  assign status.div_last  = div_cnt == DIV_CNT_W'(QUO_W - 1);
  assign status.out_free  = !res_valid || res_ready;

  ttme_ram #(
    .WIDTH(IVAL_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wr_pos),
    .wdata (gap_full[IVAL_W-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result selection
  always_comb begin
    if (med == '0) begin
      tempo_val = TEMPO_SAT;
    end else if (quo > QUO_W'(TEMPO_SAT)) begin
      tempo_val = TEMPO_SAT;
    end else begin
      tempo_val = quo[TEMPO_W-1:0];
    end
    priority if (downbeat) begin
      kind_val = KIND_DOWNBEAT;
    end else if (med == '0 || tempo_val < tempo_min || tempo_val > tempo_max) begin
      kind_val = KIND_OUT_OF_RANGE;
    end else if (fill >= CNT_W'(2)) begin
      kind_val = KIND_PHASE_RESET;
    end else begin
      kind_val = KIND_SINGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_thr   <= GAP_THR_RST;
      tempo_min <= TEMPO_MIN_RST;
      tempo_max <= TEMPO_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAP_THRESHOLD: gap_thr   <= cfg_data[IVAL_W-1:0];
        REG_TEMPO_MIN:     tempo_min <= cfg_data[TEMPO_W-1:0];
        REG_TEMPO_MAX:     tempo_max <= cfg_data[TEMPO_W-1:0];
        default: ;
      endcase
    end
  end

  // history control
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      last_time     <= '0;
      wr_pos        <= '0;
      fill          <= '0;
    end else if (cmd.downbeat) begin
      have_previous <= 1'b1;
      last_time     <= now_time;
      wr_pos        <= '0;
      fill          <= '0;
    end else if (cmd.store) begin
      have_previous <= 1'b1;
      last_time     <= now_time;
      wr_pos        <= (wr_pos == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wr_pos + IDX_W'(1);
      if (fill < CNT_W'(HISTORY_DEPTH)) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan;
    end
  end

  // median search and division
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_time <= tap_time_us;
    end
    if (cmd.downbeat) begin
      downbeat <= 1'b1;
    end
    if (cmd.store) begin
      downbeat <= 1'b0;
      cand_idx <= '0;
    end
    if (cmd.next_i) begin
      cand_idx <= cand_idx + IDX_W'(1);
    end
    if (cmd.load_cand) begin
      cand     <= ram_rdata;
      scan_idx <= '0;
      below    <= '0;
      upto     <= '0;
    end
    if (cmd.scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (cmp_valid) begin
      if (ram_rdata < cand) below <= below + CNT_W'(1);
      if (ram_rdata <= cand) upto <= upto + CNT_W'(1);
    end
    if (cmd.take_med) begin
      med     <= status.hit ? cand : '0;
      num_sh  <= TEMPO_NUM;
      quo     <= '0;
      rem     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      num_sh  <= num_sh << 1;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (trial_ge) begin
        rem <= IVAL_W'(trial - {1'b0, med});
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= trial[IVAL_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      tap_kind       <= kind_val;
      tempo_q8       <= downbeat ? '0 : tempo_val;
      interval_count <= COUNT_W'(fill);
    end
  end

endmodule
`default_nettype wire

// ===== sv/tap_tempo_median_estimator.sv =====
// one tap at a time; a downbeat result passes the GAP and FINISH states to the result register
// other taps store the interval, then try up to n candidates (n stored intervals) in turn,
// each by a rank-count median scan over the interval ram, then a 34-step serial divider runs;
// the next tap is taken in the cycle after the result is loaded, also while it waits
// synchronous active-high reset clears history, config to defaults and the result valid flag
`default_nettype none
module tap_tempo_median_estimator import ttme_pkg::*; #(
  parameter int HISTORY_DEPTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  ttme_tap_if.sink                  tap,
  ttme_res_if.source                result
);

  cmd_t    cmd;
  status_t status;

  ttme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tap_valid (tap.valid),
    .tap_ready (tap.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ttme_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .tap_time_us    (tap.tap_time_us),
    .cmd            (cmd),
    .status         (status),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .tap_kind       (result.tap_kind),
    .tempo_q8       (result.tempo_q8),
    .interval_count (result.interval_count)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_tap_tempo_median_estimator.sv =====
`timescale 1ns / 100ps
module tb_tap_tempo_median_estimator;
  import ttme_pkg::*;

  localparam int DEPTH = 8;
  localparam longint unsigned BEAT_NUM_Q8 = 64'd15360000000;
  localparam longint unsigned TEMPO_TOP = 64'd1048575;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 140;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_TAPS = 235;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

  typedef struct {
    tap_kind_t          kind;
    logic [TEMPO_W-1:0] tempo;
    logic [COUNT_W-1:0] count;
  } tempo_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  ttme_tap_if tap_ch ();
  ttme_res_if res_ch ();

  tap_tempo_median_estimator #(.HISTORY_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tap       (tap_ch),
    .result    (res_ch)
  );

  always #6 clk = ~clk;

  // tempo estimate state, mirrors the block
  logic [IVAL_W-1:0]  gap_limit = 24'd2000000;
  logic [TEMPO_W-1:0] tempo_lo = 20'd15360;
  logic [TEMPO_W-1:0] tempo_hi = 20'd61440;
  bit                 seen_tap = 1'b0;
  logic [TIME_W-1:0]  last_stamp = '0;
  int unsigned        interval_ring [DEPTH];
  int unsigned        ring_pos = 0;
  int unsigned        ring_fill = 0;

  logic [TIME_W-1:0]  tap_times [$];
  tempo_result_t      tempo_expected [$];
  logic [TIME_W-1:0]  stamp = '0;

  int taps_queued = 0;
  int taps_accepted = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit tap_fire = 1'b0;
  bit calm = 1'b0;
  bit want_long_hold = 1'b0;

  function automatic tempo_result_t estimate_tempo(input logic [TIME_W-1:0] now);
    tempo_result_t     r;
    logic [TIME_W-1:0] gap;
    int unsigned       sorted [$];
    int unsigned       v;
    int unsigned       med;
    int                j;
    longint unsigned   q;
    gap = now - last_stamp;
    if (!seen_tap || gap > TIME_W'(gap_limit)) begin
      ring_fill = 0;
      ring_pos = 0;
      r.kind = KIND_DOWNBEAT;
      r.tempo = '0;
    end else begin
      interval_ring[ring_pos] = gap[IVAL_W-1:0];
      ring_pos = (ring_pos + 1) % DEPTH;
      if (ring_fill < DEPTH) ring_fill++;
      for (int i = 0; i < ring_fill; i++) begin
        v = interval_ring[i];
        j = 0;
        while (j < sorted.size() && sorted[j] <= v) j++;
        sorted.insert(j, v);
      end
      // upper median
      med = sorted[ring_fill / 2];
      if (med == 0) begin
        r.tempo = '1;
        r.kind = KIND_OUT_OF_RANGE;
      end else begin
        q = BEAT_NUM_Q8 / longint'(med);
        if (q > TEMPO_TOP) q = TEMPO_TOP;
        r.tempo = TEMPO_W'(q);
        if (r.tempo >= tempo_lo && r.tempo <= tempo_hi) begin
          r.kind = (ring_fill >= 2) ? KIND_PHASE_RESET : KIND_SINGLE;
        end else begin
          r.kind = KIND_OUT_OF_RANGE;
        end
      end
    end
    last_stamp = now;
    seen_tap = 1'b1;
    r.count = COUNT_W'(ring_fill);
    return r;
  endfunction

  // checker and watchdog
  always @(posedge clk) begin : monitor
    tempo_result_t want;
    bit            res_fire;
    tap_fire = !rst && tap_ch.valid && tap_ch.ready;
    res_fire = !rst && res_ch.valid && res_ch.ready;
    if (tap_fire) begin
      tempo_expected.push_back(estimate_tempo(tap_ch.tap_time_us));
      taps_accepted++;
    end
    if (res_fire) begin
      if (tempo_expected.size() == 0) begin
        $display("%0t: result transaction with none expected: kind %0d tempo %0d count %0d",
                 $time, res_ch.tap_kind, res_ch.tempo_q8, res_ch.interval_count);
        errors++;
      end else begin
        want = tempo_expected.pop_front();
        if (res_ch.tap_kind !== want.kind) begin
          $display("%0t: tap_kind expected %0d actual %0d", $time, want.kind, res_ch.tap_kind);
          errors++;
        end
        if (res_ch.tempo_q8 !== want.tempo) begin
          $display("%0t: tempo_q8 expected %0d actual %0d", $time, want.tempo, res_ch.tempo_q8);
          errors++;
        end
        if (res_ch.interval_count !== want.count) begin
          $display("%0t: interval_count expected %0d actual %0d", $time, want.count,
                   res_ch.interval_count);
          errors++;
        end
      end
    end
    if (tap_fire || res_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // tap driver
  always @(negedge clk) begin
    if (rst) begin
      tap_ch.valid <= 1'b0;
    end else if (!tap_ch.valid || tap_fire) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        tap_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(7, 0) == 0) begin
        send_gap <= $urandom_range(4, 0);
        tap_ch.valid <= 1'b0;
      end else if (tap_times.size() != 0) begin
        tap_ch.valid <= 1'b1;
        tap_ch.tap_time_us <= tap_times.pop_front();
      end else begin
        tap_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (want_long_hold) begin
      want_long_hold <= 1'b0;
      hold_left <= LONG_HOLD;
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(5, 0) == 0) begin
      stall_left <= $urandom_range(4, 0);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic tap_at(input logic [TIME_W-1:0] t);
    stamp = t;
    tap_times.push_back(t);
    taps_queued++;
  endtask

  task automatic tap_after(input logic [TIME_W-1:0] d);
    tap_at(stamp + d);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_GAP_THRESHOLD: gap_limit = value;
      REG_TEMPO_MIN:     tempo_lo = value[TEMPO_W-1:0];
      REG_TEMPO_MAX:     tempo_hi = value[TEMPO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (taps_accepted != taps_queued || tempo_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [TIME_W-1:0] next_gap(input int unsigned base);
    int unsigned g;
    case ($urandom_range(15, 0))
      0: return '0;
      1: return TIME_W'(gap_limit);
      2: return TIME_W'(gap_limit) + 1;
      3: return TIME_W'({$urandom(), $urandom()});
      4: return TIME_W'($urandom_range(gap_limit, 0));
      default: begin
        g = base - base / 16 + $urandom_range(base / 8, 0);
        if (gap_limit != 0 && g > gap_limit) g = gap_limit;
        return TIME_W'(g);
      end
    endcase
  endfunction

  // tap sequences with a steady beat and some jitter, broken by odd gaps
  task automatic random_taps(input int n);
    int          made;
    int          len;
    int unsigned span;
    int unsigned base;
    made = 0;
    while (made < n) begin
      tap_at(TIME_W'({$urandom(), $urandom()}));
      made++;
      span = (gap_limit == 0) ? 1 : gap_limit;
      if (span > 1000000 && $urandom_range(3, 0) != 0) begin
        base = $urandom_range(1000000, 200000);
      end else begin
        base = $urandom_range(span, 1);
      end
      len = $urandom_range(20, 2);
      repeat (len) begin
        tap_after(next_gap(base));
        made++;
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] lo,
                           input logic [CFG_W-1:0] hi, input bit long_hold);
    write_reg(REG_GAP_THRESHOLD, thr);
    write_reg(REG_TEMPO_MIN, lo);
    write_reg(REG_TEMPO_MAX, hi);
    cfg_we <= 1'b0;
    if (long_hold) want_long_hold = 1'b1;
    random_taps(PHASE_TAPS);
    wait_drained();
  endtask

  initial begin
    tap_ch.valid = 1'b0;
    tap_ch.tap_time_us = '0;
    res_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: downbeat, steady beat, threshold edge, zero gap, wrap
    tap_at('0);
    tap_after(500000);
    tap_after(500000);
    tap_after(400000);
    tap_after(2000000);
    tap_after(2000001);
    tap_after(0);
    tap_after(1);
    tap_after(200000);
    tap_at(stamp - 5);
    tap_at(48'hFFFF_FFFF_FFFF - 99999);
    tap_after(250000);
    tap_after(249999);
    repeat (7) tap_after(200000);
    tap_after(2000001);
    tap_after(1000000);
    tap_after(1000001);
    tap_at('1);
    tap_at('0);
    wait_drained();

    run_phase(24'd0, 24'd15360, 24'd61440, 1'b0);
    run_phase(24'hFF_FFFF, 24'd0, 24'hF_FFFF, 1'b1);
    run_phase(24'd2000000, 24'hF_FFFF, 24'd0, 1'b0);
    run_phase(24'($urandom_range(3000000, 1)), 24'($urandom()), 24'($urandom()), 1'b0);
    run_phase(24'd2500000, 24'($urandom_range(30000, 0)) | (24'($urandom()) & 24'hF0_0000),
              24'($urandom_range(1048575, 30000)), 1'b0);
    write_reg(REG_SPARE, 24'($urandom()));
    run_phase(24'($urandom_range(20000, 1)), 24'd0, 24'hF_FFFF, 1'b0);
    run_phase(24'($urandom()), 24'($urandom_range(40000, 0)),
              24'($urandom_range(1048575, 20000)), 1'b0);
    calm = 1'b1;
    run_phase(24'd2000000, 24'd15360, 24'd61440, 1'b0);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
